>>> rtl/core/tgpc_pkg.sv
// Package for the text/graphics pixel composer: action codes, register map,
// reset values and the structs shared by the core modules. No dependencies.
`default_nettype none

package tgpc_pkg;

   // Action codes of a request transaction
   localparam logic [2:0] ACT_PORT_WR    = 3'd0;
   localparam logic [2:0] ACT_PORT_RD    = 3'd1;
   localparam logic [2:0] ACT_MODE_WR    = 3'd2;
   localparam logic [2:0] ACT_FRAME_TICK = 3'd3;
   localparam logic [2:0] ACT_RENDER     = 3'd4;

   // Register indexes (byte address is 4 * index)
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_DISPLAY_ENABLE = 3'd0;
   localparam logic [2:0] REG_CURSOR_DISABLE = 3'd1;
   localparam logic [2:0] REG_CURSOR_ADDR    = 3'd2;
   localparam logic [2:0] REG_CURSOR_START   = 3'd3;
   localparam logic [2:0] REG_CURSOR_END     = 3'd4;
   localparam logic [2:0] REG_BLINK_MODE     = 3'd5;
   localparam logic [2:0] REG_CHAR_HEIGHT    = 3'd6;
   localparam logic [2:0] REG_ATTR_BLINK     = 3'd7;

   // Cursor blink modes
   localparam logic [1:0] BLINK_STEADY = 2'd0;
   localparam logic [1:0] BLINK_HIDDEN = 2'd1;
   localparam logic [1:0] BLINK_BIT3   = 2'd2;
   localparam logic [1:0] BLINK_BIT4   = 2'd3;

   localparam logic [4:0] PALETTE_PORT_BASE = 5'b00110; // ports 0x30-0x37
   localparam logic [7:0] COLOUR_MASK_RESET = 8'hfe;
   localparam logic [2:0] MONO_PAGE_RESET   = 3'd7;
   localparam logic [2:0] COLOUR_WHITE      = 3'd7;
   localparam logic [7:0] READ_MISS_DATA    = 8'hff;
   localparam int unsigned TEXT_LINES       = 8;

   typedef struct packed {
      logic        display_enable;
      logic        cursor_disable;
      logic [10:0] cursor_addr;
      logic [4:0]  cursor_start;
      logic [4:0]  cursor_end;
      logic [1:0]  cursor_blink_mode;
      logic [3:0]  char_height;
      logic        attr_blink;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  port_addr;
      logic [7:0]  port_data;
      logic [7:0]  plane_b;
      logic [7:0]  plane_r;
      logic [7:0]  plane_g;
      logic        text_present;
      logic [7:0]  font_row;
      logic [5:0]  text_attr;
      logic [3:0]  cell_line;
      logic [10:0] text_addr;
      logic        text_half;
   } item_type;

   typedef struct packed {
      logic [7:0][2:0] palette;
      logic [7:0]      colour_mask;
      logic [2:0]      mono_page;
      logic            text_in_colour;
      logic            text_is_wide;
      logic [4:0]      blink_counter;
   } mode_type;

endpackage

`default_nettype wire

>>> rtl/core/tgpc_ifaces.sv
// Valid/ready channel interfaces for the pixel composer request and response.
// Standalone; field widths follow the tgpc_pkg item layout.
`default_nettype none

interface tgpc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  port_addr;
   logic [7:0]  port_data;
   logic [7:0]  plane_b;
   logic [7:0]  plane_r;
   logic [7:0]  plane_g;
   logic        text_present;
   logic [7:0]  font_row;
   logic [5:0]  text_attr;
   logic [3:0]  cell_line;
   logic [10:0] text_addr;
   logic        text_half;

   modport source (
      output valid, action, port_addr, port_data, plane_b, plane_r, plane_g,
             text_present, font_row, text_attr, cell_line, text_addr, text_half,
      input  ready
   );
   modport sink (
      input  valid, action, port_addr, port_data, plane_b, plane_r, plane_g,
             text_present, font_row, text_attr, cell_line, text_addr, text_half,
      output ready
   );
endinterface

interface tgpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [23:0] pixels;

   modport source (output valid, read_data, pixels, input ready);
   modport sink   (input valid, read_data, pixels, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tgpc_csr.sv
// APB-style configuration registers of the pixel composer.
// Depends on tgpc_pkg for the register map and cfg_type.
`default_nettype none

module tgpc_csr
   import tgpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_enable    <= 1'b1;
         cfg_ff.cursor_disable    <= 1'b0;
         cfg_ff.cursor_addr       <= '0;
         cfg_ff.cursor_start      <= '0;
         cfg_ff.cursor_end        <= 5'd7;
         cfg_ff.cursor_blink_mode <= BLINK_STEADY;
         cfg_ff.char_height       <= 4'd8;
         cfg_ff.attr_blink        <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DISPLAY_ENABLE: cfg_ff.display_enable    <= pwdata[0];
            REG_CURSOR_DISABLE: cfg_ff.cursor_disable    <= pwdata[0];
            REG_CURSOR_ADDR:    cfg_ff.cursor_addr       <= pwdata[10:0];
            REG_CURSOR_START:   cfg_ff.cursor_start      <= pwdata[4:0];
            REG_CURSOR_END:     cfg_ff.cursor_end        <= pwdata[4:0];
            REG_BLINK_MODE:     cfg_ff.cursor_blink_mode <= pwdata[1:0];
            REG_CHAR_HEIGHT:    cfg_ff.char_height       <= pwdata[3:0];
            REG_ATTR_BLINK:     cfg_ff.attr_blink        <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_DISPLAY_ENABLE: prdata[0]    = cfg_ff.display_enable;
         REG_CURSOR_DISABLE: prdata[0]    = cfg_ff.cursor_disable;
         REG_CURSOR_ADDR:    prdata[10:0] = cfg_ff.cursor_addr;
         REG_CURSOR_START:   prdata[4:0]  = cfg_ff.cursor_start;
         REG_CURSOR_END:     prdata[4:0]  = cfg_ff.cursor_end;
         REG_BLINK_MODE:     prdata[1:0]  = cfg_ff.cursor_blink_mode;
         REG_CHAR_HEIGHT:    prdata[3:0]  = cfg_ff.char_height;
         REG_ATTR_BLINK:     prdata[0]    = cfg_ff.attr_blink;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/tgpc_mode_state.sv
// Palette, colour mask, mode port state and blink counter of the composer;
// updated as each transaction leaves the input register. Depends on tgpc_pkg.
`default_nettype none

module tgpc_mode_state
   import tgpc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire item_type item,
   output mode_type      mode,
   output logic [7:0]    read_data
);

   mode_type mode_ff;
   mode_type mode_in;
   logic     pal_port;
   logic [2:0] entry;

   assign pal_port = (item.port_addr[7:3] == PALETTE_PORT_BASE);
   assign entry    = item.port_addr[2:0];
   assign mode     = mode_ff;

   always_comb begin
      mode_in = mode_ff;
      unique case (item.action)
         ACT_PORT_WR: begin
            if (pal_port) begin
               mode_in.palette[entry]     = item.port_data[2:0];
               mode_in.colour_mask[entry] = |item.port_data[2:0];
            end
         end
         ACT_MODE_WR: begin
            mode_in.mono_page      = item.port_data[2:0];
            mode_in.text_in_colour = ~item.port_data[7];
            mode_in.text_is_wide   = ~item.port_data[6];
         end
         ACT_FRAME_TICK: mode_in.blink_counter = mode_ff.blink_counter + 5'd1;
         default: ;
      endcase
   end

   always_comb begin
      read_data = '0;
      if (item.action == ACT_PORT_RD) begin
         read_data = pal_port ? {5'd0, mode_ff.palette[entry]} : READ_MISS_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            mode_ff.palette[i] <= 3'(i);
         end
         mode_ff.colour_mask    <= COLOUR_MASK_RESET;
         mode_ff.mono_page      <= MONO_PAGE_RESET;
         mode_ff.text_in_colour <= 1'b0;
         mode_ff.text_is_wide   <= 1'b1;
         mode_ff.blink_counter  <= '0;
      end else if (step_en) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tgpc_compose.sv
// Pixel composition of one 8-pixel group: graphics, text overlay, cursor
// and blanking. Pure logic; depends on tgpc_pkg for cfg_type/mode_type.
`default_nettype none

module tgpc_compose
   import tgpc_pkg::*;
(
   input  wire item_type item,
   input  wire mode_type mode,
   input  wire cfg_type  cfg,
   output logic [23:0]   pixels
);

   logic [7:0][2:0] px;
   logic [7:0]      mono_pat;
   logic [7:0]      text_pat;
   logic [2:0]      text_col;
   logic            secret;
   logic            text_on;
   logic            cursor_shown;
   logic            cursor_hit;
   logic [2:0]      bit_sel;

   assign mono_pat = (mode.mono_page[0] ? item.plane_b : 8'd0)
                   | (mode.mono_page[1] ? item.plane_r : 8'd0)
                   | (mode.mono_page[2] ? item.plane_g : 8'd0);

   assign secret   = item.text_attr[3] | (item.text_attr[4] & cfg.attr_blink);
   assign text_pat = secret ? 8'd0 : (item.text_attr[5] ? ~item.font_row : item.font_row);
   assign text_col = mode.text_in_colour ? item.text_attr[2:0] : COLOUR_WHITE;
   assign text_on  = item.text_present & (32'(item.cell_line) < TEXT_LINES);

   always_comb begin
      unique case (cfg.cursor_blink_mode)
         BLINK_STEADY: cursor_shown = 1'b1;
         BLINK_HIDDEN: cursor_shown = 1'b0;
         BLINK_BIT3:   cursor_shown = mode.blink_counter[3];
         BLINK_BIT4:   cursor_shown = mode.blink_counter[4];
      endcase
   end

   assign cursor_hit = item.text_present & ~cfg.cursor_disable & cursor_shown
                     & (item.text_addr == cfg.cursor_addr)
                     & ({1'b0, item.cell_line} >= cfg.cursor_start)
                     & ({1'b0, item.cell_line} <= cfg.cursor_end)
                     & (item.cell_line < cfg.char_height);

   // Pixel i is leftmost at i = 0, taken from plane bit 7 - i
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         bit_sel = 3'(7 - i);
         if (mode.colour_mask != 8'd0) begin
            px[i] = mode.palette[{item.plane_g[bit_sel], item.plane_r[bit_sel],
                                  item.plane_b[bit_sel]}];
         end else begin
            px[i] = mono_pat[bit_sel] ? COLOUR_WHITE : 3'd0;
         end
         if (mode.text_is_wide) begin
            // each pattern bit covers two pixels, half picks the nibble
            bit_sel = (item.text_half ? 3'd3 : 3'd7) - 3'(i / 2);
         end
         if (text_on && text_pat[bit_sel]) begin
            px[i] = text_col;
         end
         if (cursor_hit) begin
            px[i] = COLOUR_WHITE;
         end
      end
   end

   always_comb begin
      pixels = '0;
      if (cfg.display_enable) begin
         for (int i = 0; i < 8; i++) begin
            pixels[23 - 3*i -: 3] = px[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/text_graphics_pixel_composer_core.sv
// Text/graphics pixel composer: one transaction in, one result out.
// Path: an accepted request enters the input register, then the result register once
// that is free. Throughput: one transaction per cycle while rsp_chan.ready holds,
// set by the single compose stage between the two registers; state updates in order.
// Reset (synchronous, active high) restores palette, mode state, blink counter
// and configuration registers, and empties both pipeline registers.
`default_nettype none

module text_graphics_pixel_composer_core
   import tgpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tgpc_req_if.sink                   req_chan,
   tgpc_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   item_type    item_ff;
   logic        item_vld_ff;
   logic        rsp_vld_ff;
   logic [7:0]  rsp_read_data_ff;
   logic [23:0] rsp_pixels_ff;
   logic        advance;
   logic        req_take;
   cfg_type     cfg;
   mode_type    mode;
   logic [7:0]  read_data;
   logic [23:0] pixels;

   tgpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgpc_mode_state u_mode_state (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item      (item_ff),
      .mode      (mode),
      .read_data (read_data)
   );

   tgpc_compose u_compose (
      .item   (item_ff),
      .mode   (mode),
      .cfg    (cfg),
      .pixels (pixels)
   );

   // Move the held transaction into the result register when it is free
   assign advance  = item_vld_ff & (~rsp_vld_ff | rsp_chan.ready);
   assign req_chan.ready = ~item_vld_ff | advance;
   assign req_take = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_vld_ff <= 1'b1;
         end else if (advance) begin
            item_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.action       <= req_chan.action;
         item_ff.port_addr    <= req_chan.port_addr;
         item_ff.port_data    <= req_chan.port_data;
         item_ff.plane_b      <= req_chan.plane_b;
         item_ff.plane_r      <= req_chan.plane_r;
         item_ff.plane_g      <= req_chan.plane_g;
         item_ff.text_present <= req_chan.text_present;
         item_ff.font_row     <= req_chan.font_row;
         item_ff.text_attr    <= req_chan.text_attr;
         item_ff.cell_line    <= req_chan.cell_line;
         item_ff.text_addr    <= req_chan.text_addr;
         item_ff.text_half    <= req_chan.text_half;
      end
      if (advance) begin
         rsp_read_data_ff <= read_data;
         rsp_pixels_ff    <= (item_ff.action == ACT_RENDER) ? pixels : 24'd0;
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.read_data = rsp_read_data_ff;
   assign rsp_chan.pixels    = rsp_pixels_ff;

endmodule

`default_nettype wire
